// ----- src/assert_macros.svh -----
// assertion macros shared by the dib pixel writer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define DPW_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define DPW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/dpw_pkg.sv -----
// types, codes and constants of the dib pixel writer
package dpw_pkg;

  localparam int ADDR_W    = 26;
  localparam int GEOM_W    = 13;
  localparam int DEPTH_W   = 3;
  localparam int POS_W     = 12;
  localparam int CHAN_W    = 8;
  localparam int RGB_W     = 3 * CHAN_W;
  localparam int PIDX_W    = 8;
  localparam int LIM_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_MAX_HEIGHT    = 4096;
  localparam int DEF_PALETTE_DEPTH = 256;

  // palette entries searched at each indexed depth
  localparam logic [LIM_W-1:0] PAL_N_1BPP = 9'd2;
  localparam logic [LIM_W-1:0] PAL_N_4BPP = 9'd16;
  localparam logic [LIM_W-1:0] PAL_N_8BPP = 9'd216;

  localparam logic [CHAN_W-1:0] MASK_HI_NIBBLE = 8'hF0;
  localparam logic [CHAN_W-1:0] MASK_LO_NIBBLE = 8'h0F;
  localparam logic [CHAN_W-1:0] MASK_FULL      = 8'hFF;

  // depth_code values
  localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_4BPP  = 3'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_16BPP = 3'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_24BPP = 3'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd5;

  // cmd values
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_CODE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  // search token walking down the palette cells
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [PIDX_W-1:0] index;
  } search_tok_t;

  // stage enables of the address generator
  typedef struct packed {
    logic calc_en;
    logic mul_en;
  } addr_ctrl_t;

endpackage

// ----- src/dpw_cell.sv -----
// one palette cell: holds one entry and checks the passing search token
module dpw_cell
  import dpw_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_en,
  input  logic [PIDX_W-1:0] load_index,
  input  logic [RGB_W-1:0]  load_rgb,
  input  logic [RGB_W-1:0]  search_rgb,
  input  logic [LIM_W-1:0]  search_lim,
  input  search_tok_t       prev_tok,
  output search_tok_t       tok
);

  localparam logic [PIDX_W-1:0] MY_INDEX = PIDX_W'(CELL_INDEX);
  localparam logic [LIM_W-1:0]  MY_RANK  = LIM_W'(CELL_INDEX);

  logic [RGB_W-1:0] entry;
  logic             match;
  search_tok_t      tok_next;

  always_ff @(posedge clk) begin
    if (load_en && (load_index == MY_INDEX)) begin
      entry <= load_rgb;
    end
  end

  assign match = (entry == search_rgb) && (MY_RANK < search_lim);

  // first hit from the top wins, later cells pass it on
  always_comb begin
    tok_next = prev_tok;
    if (prev_tok.valid && !prev_tok.hit && match) begin
      tok_next.hit   = 1'b1;
      tok_next.index = MY_INDEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

endmodule

// ----- src/dpw_addr_gen.sv -----
// row stride, range check and byte address of a pixel, two register stages
module dpw_addr_gen
  import dpw_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  addr_ctrl_t         ctrl,
  input  logic [GEOM_W-1:0]  image_width,
  input  logic [GEOM_W-1:0]  image_height,
  input  logic [DEPTH_W-1:0] depth_code,
  input  logic [POS_W-1:0]   pixel_row,
  input  logic [POS_W-1:0]   pixel_col,
  output logic [ADDR_W-1:0]  base_addr,
  output logic               out_of_range
);

  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int HW       = $clog2(MAX_HEIGHT + 1);
  localparam int SUM_W    = WW + 6;
  localparam int STRIDE_W = WW + 3;
  localparam int COFF_W   = POS_W + 2;
  localparam int PROD_W   = HW + STRIDE_W;

  logic [WW-1:0]       w_sat;
  logic [HW-1:0]       h_sat;
  logic [SUM_W-1:0]    row_bits;
  logic [SUM_W-1:0]    row_bits_rnd;
  logic                depth_bad;
  logic [COFF_W-1:0]   col_off_next;
  logic [STRIDE_W-1:0] stride_next;
  logic [HW-1:0]       diff_next;
  logic                oor_next;

  logic [STRIDE_W-1:0] stride;
  logic [HW-1:0]       diff;
  logic [COFF_W-1:0]   col_off;
  logic [PROD_W-1:0]   prod;

  assign w_sat = (32'(image_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(image_width);
  assign h_sat = (32'(image_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(image_height);

  always_comb begin
    depth_bad = 1'b0;
    case (depth_code)
      DEPTH_1BPP: begin
        row_bits     = SUM_W'(w_sat);
        col_off_next = COFF_W'(pixel_col) >> 3;
      end
      DEPTH_4BPP: begin
        row_bits     = SUM_W'(w_sat) << 2;
        col_off_next = COFF_W'(pixel_col) >> 1;
      end
      DEPTH_8BPP: begin
        row_bits     = SUM_W'(w_sat) << 3;
        col_off_next = COFF_W'(pixel_col);
      end
      DEPTH_16BPP: begin
        row_bits     = SUM_W'(w_sat) << 4;
        col_off_next = COFF_W'(pixel_col) << 1;
      end
      DEPTH_24BPP: begin
        row_bits     = (SUM_W'(w_sat) << 4) + (SUM_W'(w_sat) << 3);
        col_off_next = (COFF_W'(pixel_col) << 1) + COFF_W'(pixel_col);
      end
      DEPTH_32BPP: begin
        row_bits     = SUM_W'(w_sat) << 5;
        col_off_next = COFF_W'(pixel_col) << 2;
      end
      default: begin
        row_bits     = '0;
        col_off_next = '0;
        depth_bad    = 1'b1;
      end
    endcase
  end

  // round up to whole 32-bit words, then count bytes
  assign row_bits_rnd = row_bits + SUM_W'(31);
  assign stride_next  = {row_bits_rnd[SUM_W-1:5], 2'b00};

  // bottom-up buffer: image row 0 is the last stored row
  assign diff_next = h_sat - HW'(pixel_row) - HW'(1);
  assign oor_next  = depth_bad || (32'(pixel_row) >= 32'(h_sat))
                     || (32'(pixel_col) >= 32'(w_sat));

  always_ff @(posedge clk) begin
    if (ctrl.calc_en) begin
      stride       <= stride_next;
      diff         <= diff_next;
      col_off      <= col_off_next;
      out_of_range <= oor_next;
    end
  end

  assign prod = PROD_W'(diff) * PROD_W'(stride);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      base_addr <= ADDR_W'(prod) + ADDR_W'(col_off);
    end
  end

endmodule

// ----- src/dib_pixel_writer_top.sv -----
// top level of the dib pixel writer: control, palette cell row and result register
// Turns pixel writes into masked byte writes for a bottom-up DIB frame buffer
// whose rows are padded to 4 bytes. A load transaction (cmd 0) writes one
// palette entry in the cycle it is accepted and gives no result. A pixel
// transaction gets its range check and stride in ST_CALC, its row-times-stride
// multiply in ST_MUL, and then emits its byte writes one per cycle
// while the result register is free: 1 byte at 1, 4 and 8 bpp, 2 at 16 bpp,
// 3 at 24 bpp, 4 at 32 bpp, or a single out_of_range result. In-range pixels
// at indexed depths first send a search token down the row of PALETTE_DEPTH
// palette cells, one cell per clock, from the top entry down. One pixel is
// worked on at a time; req_stall is low only between pixels, and the next
// transaction may be taken while the final result still waits.
// The palette has no reset: only entries that were loaded may be searched.
`include "assert_macros.svh"

module dib_pixel_writer_top
  import dpw_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GEOM_W-1:0]    cfg_data,
  // request channel
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 cmd,
  input  logic [POS_W-1:0]     pixel_row,
  input  logic [POS_W-1:0]     pixel_col,
  input  logic [PIDX_W-1:0]    palette_index,
  input  logic [CHAN_W-1:0]    red,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    blue,
  input  logic [CHAN_W-1:0]    alpha,
  // result channel
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [ADDR_W-1:0]    byte_address,
  output logic [CHAN_W-1:0]    byte_data,
  output logic [CHAN_W-1:0]    bit_mask,
  output logic                 last,
  output logic                 out_of_range
);

  // configuration registers
  logic [GEOM_W-1:0]  image_width;
  logic [GEOM_W-1:0]  image_height;
  logic [DEPTH_W-1:0] depth_code;

  // latched pixel transaction
  logic [POS_W-1:0]  row_q;
  logic [POS_W-1:0]  col_q;
  logic [RGB_W-1:0]  rgb_q;
  logic [CHAN_W-1:0] alpha_q;

  state_t      state;
  state_t      state_next;
  logic        req_accept;
  logic        pal_load;
  logic        indexed;
  logic        search_start;
  logic        q_capture;
  logic        out_load;
  logic        emit_last;
  addr_ctrl_t  addr_ctrl;

  logic [ADDR_W-1:0] base_addr;
  logic              oor_q;
  logic [LIM_W-1:0]  search_lim;
  logic [PIDX_W-1:0] q_idx;
  logic [1:0]        byte_idx;
  logic [1:0]        last_idx;

  logic [ADDR_W-1:0] fmt_addr;
  logic [CHAN_W-1:0] fmt_data;
  logic [CHAN_W-1:0] fmt_mask;
  logic [CHAN_W-1:0] bit_sel;

  // tok_chain[k] leaves cell k; tok_chain[PALETTE_DEPTH] is the head
  search_tok_t tok_chain [PALETTE_DEPTH+1];

  assign req_accept = req_valid && !req_stall;
  assign pal_load   = req_accept && (cmd == CMD_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= GEOM_W'(1);
      image_height <= GEOM_W'(1);
      depth_code   <= DEPTH_32BPP;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_DEPTH_CODE:   depth_code   <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept && (cmd == CMD_PIXEL)) begin
      row_q   <= pixel_row;
      col_q   <= pixel_col;
      rgb_q   <= {red, green, blue};
      alpha_q <= alpha;
    end
  end

  assign indexed = depth_code inside {DEPTH_1BPP, DEPTH_4BPP, DEPTH_8BPP};

  always_comb begin
    case (depth_code)
      DEPTH_1BPP: search_lim = PAL_N_1BPP;
      DEPTH_4BPP: search_lim = PAL_N_4BPP;
      DEPTH_8BPP: search_lim = PAL_N_8BPP;
      default:    search_lim = '0;
    endcase
  end

  // bytes per pixel, less one
  always_comb begin
    if (oor_q) begin
      last_idx = 2'd0;
    end else begin
      case (depth_code)
        DEPTH_16BPP: last_idx = 2'd1;
        DEPTH_24BPP: last_idx = 2'd2;
        DEPTH_32BPP: last_idx = 2'd3;
        default:     last_idx = 2'd0;
      endcase
    end
  end

  assign emit_last = (byte_idx == last_idx);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_accept && (cmd == CMD_PIXEL)) state_next = ST_CALC;
      end
      ST_CALC: state_next = ST_MUL;
      ST_MUL: begin
        if (!oor_q && indexed) state_next = ST_SEARCH;
        else state_next = ST_EMIT;
      end
      ST_SEARCH: begin
        if (tok_chain[0].valid) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load && emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    req_stall         = rst || (state != ST_IDLE);
    addr_ctrl.calc_en = (state == ST_CALC);
    addr_ctrl.mul_en  = (state == ST_MUL);
    search_start      = (state == ST_MUL) && !oor_q && indexed;
    q_capture         = (state == ST_SEARCH) && tok_chain[0].valid;
    out_load          = (state == ST_EMIT) && (!rsp_valid || !rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  dpw_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr_gen (
    .clk          (clk),
    .ctrl         (addr_ctrl),
    .image_width  (image_width),
    .image_height (image_height),
    .depth_code   (depth_code),
    .pixel_row    (row_q),
    .pixel_col    (col_q),
    .base_addr    (base_addr),
    .out_of_range (oor_q)
  );

  // palette cell row, token enters at the top entry
  assign tok_chain[PALETTE_DEPTH] = '{valid: search_start, hit: 1'b0, index: '0};

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    dpw_cell #(
      .CELL_INDEX (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load_en    (pal_load),
      .load_index (palette_index),
      .load_rgb   ({red, green, blue}),
      .search_rgb (rgb_q),
      .search_lim (search_lim),
      .prev_tok   (tok_chain[k+1]),
      .tok        (tok_chain[k])
    );
  end

  // no match gives index 0
  always_ff @(posedge clk) begin
    if (q_capture) begin
      q_idx <= tok_chain[0].hit ? tok_chain[0].index : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= 2'd0;
    end else if (out_load) begin
      byte_idx <= emit_last ? 2'd0 : byte_idx + 2'd1;
    end
  end

  // byte formatter
  assign bit_sel = CHAN_W'(1) << col_q[2:0];

  always_comb begin
    fmt_addr = base_addr + ADDR_W'(byte_idx);
    fmt_data = '0;
    fmt_mask = MASK_FULL;
    if (oor_q) begin
      fmt_addr = '0;
      fmt_mask = '0;
    end else begin
      case (depth_code)
        DEPTH_1BPP: begin
          fmt_mask = bit_sel;
          fmt_data = (q_idx != '0) ? bit_sel : '0;
        end
        DEPTH_4BPP: begin
          // odd column sits in the high nibble
          if (col_q[0]) begin
            fmt_mask = MASK_HI_NIBBLE;
            fmt_data = {q_idx[3:0], 4'b0000};
          end else begin
            fmt_mask = MASK_LO_NIBBLE;
            fmt_data = {4'b0000, q_idx[3:0]};
          end
        end
        DEPTH_8BPP: fmt_data = q_idx;
        DEPTH_16BPP: begin
          // rgb555 from the low 5 bits of each channel, low byte first
          if (byte_idx == 2'd0) fmt_data = {rgb_q[10:8], rgb_q[4:0]};
          else fmt_data = {1'b0, rgb_q[20:16], rgb_q[12:11]};
        end
        DEPTH_24BPP: begin
          case (byte_idx)
            2'd0:    fmt_data = rgb_q[7:0];
            2'd1:    fmt_data = rgb_q[15:8];
            default: fmt_data = rgb_q[23:16];
          endcase
        end
        DEPTH_32BPP: begin
          case (byte_idx)
            2'd0:    fmt_data = rgb_q[7:0];
            2'd1:    fmt_data = rgb_q[15:8];
            2'd2:    fmt_data = rgb_q[23:16];
            default: fmt_data = alpha_q;
          endcase
        end
        default: begin
          fmt_addr = '0;
          fmt_mask = '0;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      byte_address <= fmt_addr;
      byte_data    <= fmt_data;
      bit_mask     <= fmt_mask;
      last         <= emit_last;
      out_of_range <= oor_q;
    end
  end

  `DPW_ASSERT_IMPL(a_tok_in_search, tok_chain[0].valid, state == ST_SEARCH, "search token left the cell row outside search")
  `DPW_ASSERT_IMPL(a_byte_idx_bound, state == ST_EMIT, byte_idx <= last_idx, "byte counter beyond pixel size")
  `DPW_ASSERT_NEXT(a_last_to_idle, out_load && emit_last, state == ST_IDLE && byte_idx == 2'd0, "final byte did not end the pixel")
  `DPW_ASSERT_IMPL(a_oor_single, rsp_valid && out_of_range, last && (bit_mask == '0), "out of range result not a lone empty write")

endmodule
